// ===== src/rrq_pkg.sv =====
`timescale 1ns / 1ps

package rrq_pkg;

	// Field widths of one record and of the result
	localparam int KEY_W = 16;
	localparam int DUR_W = 10;
	localparam int SPL_W = 10;
	localparam int PRC_W = 16;
	localparam int REC_W = KEY_W + DUR_W + SPL_W + PRC_W;
	localparam int OCC_W = 5;
	localparam int MODE_W = 2;
	localparam int STATUS_W = 2;

	// Default number of records held
	localparam int QUEUE_DEPTH_DEF = 16;

	// Operation codes carried by each input transaction
	typedef enum logic [MODE_W-1:0] {
		MODE_ENQ    = 2'd0,
		MODE_DEQ    = 2'd1,
		MODE_LOOKUP = 2'd2
	} mode_t;

	// Result status codes
	typedef enum logic [STATUS_W-1:0] {
		ST_OK       = 2'd0,
		ST_FULL     = 2'd1,
		ST_EMPTY    = 2'd2,
		ST_NOTFOUND = 2'd3
	} status_t;

	// One stored record
	typedef struct packed {
		logic [KEY_W-1:0] key;
		logic [DUR_W-1:0] duration;
		logic [SPL_W-1:0] spoilage;
		logic [PRC_W-1:0] price;
	} rec_t;

	// One finished result handed from the sequencer to the output stage
	typedef struct packed {
		status_t          status;
		rec_t             rec;
		logic [OCC_W-1:0] occupancy;
		logic             is_empty;
		logic             is_full;
	} res_t;

endpackage

// ===== src/rrq_ram.sv =====
`timescale 1ns / 1ps

module rrq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write one entry, read one entry with registered data
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ===== src/rrq_ctrl.sv =====
`timescale 1ns / 1ps

module rrq_ctrl #(
	parameter int QUEUE_DEPTH = rrq_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	// input transaction
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [rrq_pkg::MODE_W-1:0]     mode,
	input  logic [rrq_pkg::KEY_W-1:0]      key,
	input  logic [rrq_pkg::DUR_W-1:0]      duration,
	input  logic [rrq_pkg::SPL_W-1:0]      spoilage,
	input  logic [rrq_pkg::PRC_W-1:0]      price,
	// record store
	output logic                           ram_we,
	output logic [$clog2(QUEUE_DEPTH)-1:0] ram_waddr,
	output rrq_pkg::rec_t                  ram_wdata,
	output logic [$clog2(QUEUE_DEPTH)-1:0] ram_raddr,
	input  rrq_pkg::rec_t                  ram_rdata,
	// finished result
	output logic                           res_valid,
	input  logic                           res_ready,
	output rrq_pkg::res_t                  res
);

	import rrq_pkg::*;

	localparam int PTR_W = $clog2(QUEUE_DEPTH);
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_SCAN = 3'b010,
		ST_FIN  = 3'b100
	} state_t;

	state_t             state_q;
	logic [PTR_W-1:0]   head_q;
	logic [PTR_W-1:0]   tail_q;
	logic [PTR_W-1:0]   scan_q;
	logic [CNT_W-1:0]   count_q;
	logic [CNT_W-1:0]   left_q;
	logic [MODE_W-1:0]  mode_q;
	logic [KEY_W-1:0]   key_q;
	status_t            status_q;
	rec_t               rec_q;

	logic is_full;
	logic is_empty;
	logic accept;
	logic hit;

	function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	assign is_full  = (count_q == CNT_W'(QUEUE_DEPTH));
	assign is_empty = (count_q == '0);
	assign in_ready = (state_q == ST_IDLE);
	assign accept   = in_valid && in_ready;

	// Write an enqueued record at the tail on the accepting edge
	assign ram_we             = accept && (mode == MODE_ENQ) && !is_full;
	assign ram_waddr          = tail_q;
	assign ram_wdata.key      = key;
	assign ram_wdata.duration = duration;
	assign ram_wdata.spoilage = spoilage;
	assign ram_wdata.price    = price;

	// Read the head while idle, then walk the scan pointer
	assign ram_raddr = (state_q == ST_IDLE) ? head_q : scan_q;

	// Shared key comparator, one stored record per cycle
	assign hit = (ram_rdata.key == key_q);

	// Sequence pointers, count and state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			head_q  <= '0;
			tail_q  <= '0;
			scan_q  <= '0;
			count_q <= '0;
			left_q  <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						unique case (mode)
							MODE_ENQ: begin
								if (!is_full) begin
									tail_q  <= next_ptr(tail_q);
									count_q <= count_q + 1'b1;
								end
								state_q <= ST_FIN;
							end
							MODE_DEQ: begin
								state_q <= is_empty ? ST_FIN : ST_SCAN;
							end
							MODE_LOOKUP: begin
								scan_q  <= next_ptr(head_q);
								left_q  <= count_q - 1'b1;
								state_q <= is_empty ? ST_FIN : ST_SCAN;
							end
							default: begin
								state_q <= ST_FIN;
							end
						endcase
					end
				end
				ST_SCAN: begin
					if (mode_q == MODE_DEQ) begin
						head_q  <= next_ptr(head_q);
						count_q <= count_q - 1'b1;
						state_q <= ST_FIN;
					end else if (hit || (left_q == '0)) begin
						state_q <= ST_FIN;
					end else begin
						scan_q <= next_ptr(scan_q);
						left_q <= left_q - 1'b1;
					end
				end
				ST_FIN: begin
					if (res_ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Hold the transaction and build its result
	always_ff @(posedge clk) begin
		if (accept) begin
			mode_q <= mode;
			key_q  <= key;
			rec_q  <= '0;
			unique case (mode)
				MODE_ENQ:    status_q <= is_full ? ST_FULL : ST_OK;
				MODE_DEQ:    status_q <= is_empty ? ST_EMPTY : ST_OK;
				MODE_LOOKUP: status_q <= is_empty ? ST_NOTFOUND : ST_OK;
				default:     status_q <= ST_OK;
			endcase
		end else if (state_q == ST_SCAN) begin
			if ((mode_q == MODE_DEQ) || hit) begin
				rec_q <= ram_rdata;
			end else if (left_q == '0) begin
				status_q <= ST_NOTFOUND;
			end
		end
	end

	// Present the result once the queue state is final
	assign res_valid     = (state_q == ST_FIN);
	assign res.status    = status_q;
	assign res.rec       = rec_q;
	assign res.occupancy = OCC_W'(count_q);
	assign res.is_empty  = is_empty;
	assign res.is_full   = is_full;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(QUEUE_DEPTH))
		else $error("record count above queue depth");

	a_ptr_meet: assert property (@(posedge clk) disable iff (!arst_n)
		(head_q == tail_q) == (is_empty || is_full))
		else $error("head and tail disagree with record count");

	a_no_write_full: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> (state_q == ST_IDLE) && !is_full)
		else $error("store written while busy or full");

	a_deq_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN && mode_q == MODE_DEQ) |=> count_q == $past(count_q) - 1'b1)
		else $error("dequeue did not remove exactly one record");

endmodule

// ===== src/record_ring_queue_with_key_lookup_core.sv =====
`timescale 1ns / 1ps

// Ring queue of records (key, duration, spoilage, price) with key lookup.
// Input channel in_valid/in_ready carries mode, key and the record fields:
// enqueue appends at the tail, dequeue removes and returns the head, lookup
// returns the first record from head to tail whose key matches.
// Output channel out_valid/out_ready carries status, the record fields (zero
// unless a record is returned), occupancy and the empty and full flags.
// One transaction is processed at a time; in_ready is high only when the
// sequencer is idle. Enqueue and any empty/full/unused-mode case go straight
// to the result; dequeue first reads the head record; a lookup reads records
// until a match or until it has read every record held. The lookup walks
// the record store through one read port and one key comparator, one record
// per cycle.
// A new input can be taken once the sequencer has passed its result on.
// A result waits in the output register while the receiver stalls; the
// sequencer takes the next input meanwhile and holds its own result until
// that register frees.
// Reset empties the queue at once; record storage itself is not cleared.
module record_ring_queue_with_key_lookup_core #(
	parameter int QUEUE_DEPTH = rrq_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [rrq_pkg::MODE_W-1:0]   mode,
	input  logic [rrq_pkg::KEY_W-1:0]    key,
	input  logic [rrq_pkg::DUR_W-1:0]    duration,
	input  logic [rrq_pkg::SPL_W-1:0]    spoilage,
	input  logic [rrq_pkg::PRC_W-1:0]    price,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [rrq_pkg::STATUS_W-1:0] status,
	output logic [rrq_pkg::KEY_W-1:0]    rec_key,
	output logic [rrq_pkg::DUR_W-1:0]    rec_duration,
	output logic [rrq_pkg::SPL_W-1:0]    rec_spoilage,
	output logic [rrq_pkg::PRC_W-1:0]    rec_price,
	output logic [rrq_pkg::OCC_W-1:0]    occupancy,
	output logic                         is_empty,
	output logic                         is_full
);

	import rrq_pkg::*;

	localparam int PTR_W = $clog2(QUEUE_DEPTH);

	logic             ram_we;
	logic [PTR_W-1:0] ram_waddr;
	rec_t             ram_wdata;
	logic [PTR_W-1:0] ram_raddr;
	logic [REC_W-1:0] ram_rdata_raw;
	rec_t             ram_rdata;
	logic             res_valid;
	logic             res_ready;
	res_t             res;
	logic             out_valid_q;
	res_t             out_q;

	rrq_ram #(
		.WIDTH (REC_W),
		.DEPTH (QUEUE_DEPTH)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata_raw)
	);

	assign ram_rdata = ram_rdata_raw;

	rrq_ctrl #(
		.QUEUE_DEPTH (QUEUE_DEPTH)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.mode      (mode),
		.key       (key),
		.duration  (duration),
		.spoilage  (spoilage),
		.price     (price),
		.ram_we    (ram_we),
		.ram_waddr (ram_waddr),
		.ram_wdata (ram_wdata),
		.ram_raddr (ram_raddr),
		.ram_rdata (ram_rdata),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res)
	);

	// Take a new result when the output register is empty or draining
	assign res_ready = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_valid && res_ready) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Load the result payload
	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			out_q <= res;
		end
	end

	assign out_valid    = out_valid_q;
	assign status       = out_q.status;
	assign rec_key      = out_q.rec.key;
	assign rec_duration = out_q.rec.duration;
	assign rec_spoilage = out_q.rec.spoilage;
	assign rec_price    = out_q.rec.price;
	assign occupancy    = out_q.occupancy;
	assign is_empty     = out_q.is_empty;
	assign is_full      = out_q.is_full;

endmodule

// ===== dv/record_ring_queue_with_key_lookup_core_tb.sv =====
`timescale 1ns / 1ps

module record_ring_queue_with_key_lookup_core_tb;
	import rrq_pkg::*;

	localparam int DEPTH = QUEUE_DEPTH_DEF;
	localparam int CYCLE_LIMIT = 400000;
	localparam int SETTLE_CYCLES = DEPTH + 4;
	localparam logic [MODE_W-1:0] MODE_RESERVED = 2'd3;
	localparam logic [KEY_W-1:0] DUP_KEY = 16'h1234;
	localparam logic [KEY_W-1:0] ABSENT_KEY = 16'hBEEF;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                in_valid = 1'b0;
	logic                in_ready;
	logic [MODE_W-1:0]   mode = '0;
	logic [KEY_W-1:0]    key = '0;
	logic [DUR_W-1:0]    duration = '0;
	logic [SPL_W-1:0]    spoilage = '0;
	logic [PRC_W-1:0]    price = '0;
	logic                out_valid;
	logic                out_ready = 1'b0;
	logic [STATUS_W-1:0] status;
	logic [KEY_W-1:0]    rec_key;
	logic [DUR_W-1:0]    rec_duration;
	logic [SPL_W-1:0]    rec_spoilage;
	logic [PRC_W-1:0]    rec_price;
	logic [OCC_W-1:0]    occupancy;
	logic                is_empty;
	logic                is_full;

	// Shadow copy of the ring, updated at each accepted transaction
	rec_t ring_store [DEPTH];
	int ring_head = 0;
	int ring_tail = 0;
	int ring_count = 0;

	res_t pending_results [$];
	logic [KEY_W-1:0] key_pool [8];
	int mismatch_count = 0;
	int cycle_count = 0;
	int sender_idle_pct = 0;
	int recv_stall_pct = 0;

	record_ring_queue_with_key_lookup_core #(
		.QUEUE_DEPTH(DEPTH)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.mode(mode),
		.key(key),
		.duration(duration),
		.spoilage(spoilage),
		.price(price),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.status(status),
		.rec_key(rec_key),
		.rec_duration(rec_duration),
		.rec_spoilage(rec_spoilage),
		.rec_price(rec_price),
		.occupancy(occupancy),
		.is_empty(is_empty),
		.is_full(is_full)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Bound the run in case the block hangs
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	function automatic rec_t make_rec(logic [KEY_W-1:0] k, logic [DUR_W-1:0] d,
			logic [SPL_W-1:0] s, logic [PRC_W-1:0] p);
		rec_t r;
		r.key = k;
		r.duration = d;
		r.spoilage = s;
		r.price = p;
		return r;
	endfunction

	// Apply one operation to the shadow ring and return the result it should give
	function automatic res_t apply_queue_op(logic [MODE_W-1:0] op, rec_t item);
		res_t res;
		int pos;
		bit hit;
		res = '0;
		res.status = ST_OK;
		case (op)
			MODE_ENQ: begin
				if (ring_count >= DEPTH) begin
					res.status = ST_FULL;
				end else begin
					ring_store[ring_tail] = item;
					ring_tail = (ring_tail + 1) % DEPTH;
					ring_count++;
				end
			end
			MODE_DEQ: begin
				if (ring_count == 0) begin
					res.status = ST_EMPTY;
				end else begin
					res.rec = ring_store[ring_head];
					ring_head = (ring_head + 1) % DEPTH;
					ring_count--;
				end
			end
			MODE_LOOKUP: begin
				pos = ring_head;
				hit = 1'b0;
				for (int n = 0; n < ring_count && !hit; n++) begin
					if (ring_store[pos].key == item.key) begin
						res.rec = ring_store[pos];
						hit = 1'b1;
					end
					pos = (pos + 1) % DEPTH;
				end
				if (!hit)
					res.status = ST_NOTFOUND;
			end
			default: ;
		endcase
		res.occupancy = OCC_W'(ring_count);
		res.is_empty = (ring_count == 0);
		res.is_full = (ring_count >= DEPTH);
		return res;
	endfunction

	task automatic report_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] want);
		$display("MISMATCH at cycle %0d: %s got %0h expected %0h", cycle_count, what, got,
			want);
		mismatch_count++;
	endtask

	task automatic check_result(input res_t want);
		if (status !== want.status)
			report_mismatch("status", 64'(status), 64'(want.status));
		if (rec_key !== want.rec.key)
			report_mismatch("rec_key", 64'(rec_key), 64'(want.rec.key));
		if (rec_duration !== want.rec.duration)
			report_mismatch("rec_duration", 64'(rec_duration), 64'(want.rec.duration));
		if (rec_spoilage !== want.rec.spoilage)
			report_mismatch("rec_spoilage", 64'(rec_spoilage), 64'(want.rec.spoilage));
		if (rec_price !== want.rec.price)
			report_mismatch("rec_price", 64'(rec_price), 64'(want.rec.price));
		if (occupancy !== want.occupancy)
			report_mismatch("occupancy", 64'(occupancy), 64'(want.occupancy));
		if (is_empty !== want.is_empty)
			report_mismatch("is_empty", 64'(is_empty), 64'(want.is_empty));
		if (is_full !== want.is_full)
			report_mismatch("is_full", 64'(is_full), 64'(want.is_full));
	endtask

	// Check each result transaction against the oldest prediction, stall at random
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (pending_results.size() == 0)
				report_mismatch("result with none pending, status", 64'(status), '0);
			else
				check_result(pending_results.pop_front());
		end
		out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
	end

	// Offer one transaction after a random idle gap, predict it once accepted
	task automatic send_op(input logic [MODE_W-1:0] op, input rec_t item);
		while ($urandom_range(0, 99) < sender_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		mode <= op;
		key <= item.key;
		duration <= item.duration;
		spoilage <= item.spoilage;
		price <= item.price;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		pending_results.push_back(apply_queue_op(op, item));
	endtask

	// Hold the sender off until every predicted result has come back
	task automatic wait_for_results();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_results.size() != 0)
			@(posedge clk);
	endtask

	// Choose keys so lookups mostly hit and duplicates show up often
	function automatic logic [KEY_W-1:0] pick_key(logic [MODE_W-1:0] op);
		int roll;
		roll = $urandom_range(0, 99);
		if (op == MODE_LOOKUP && ring_count > 0 && roll < 60)
			return ring_store[(ring_head + $urandom_range(0, ring_count - 1)) % DEPTH].key;
		if (roll < 80)
			return key_pool[$urandom_range(0, 7)];
		return KEY_W'($urandom_range(0, 65535));
	endfunction

	task automatic test_empty_queue();
		send_op(MODE_DEQ, make_rec('0, '0, '0, '0));
		send_op(MODE_LOOKUP, make_rec('0, '0, '0, '0));
		send_op(MODE_RESERVED, make_rec('1, '1, '1, '1));
		wait_for_results();
	endtask

	task automatic test_fill_and_search();
		rec_t item;
		// Fill to capacity: all-ones, all-zeros, then alternating patterns with a duplicate key
		for (int i = 0; i < DEPTH; i++) begin
			if (i == 0)
				item = make_rec('1, '1, '1, '1);
			else if (i == 1)
				item = make_rec('0, '0, '0, '0);
			else
				item = make_rec((i == 4 || i == 9) ? DUP_KEY : KEY_W'(16'h0100 + i),
					(i % 2) ? 10'h155 : 10'h2AA, (i % 2) ? 10'h2AA : 10'h155,
					{8'(i), ~8'(i)});
			send_op(MODE_ENQ, item);
		end
		send_op(MODE_ENQ, make_rec(ABSENT_KEY, '1, '0, '1));
		send_op(MODE_LOOKUP, make_rec('1, '0, '0, '0));
		send_op(MODE_LOOKUP, make_rec(DUP_KEY, '0, '0, '0));
		send_op(MODE_LOOKUP, make_rec(KEY_W'(16'h0100 + DEPTH - 1), '0, '0, '0));
		send_op(MODE_LOOKUP, make_rec(ABSENT_KEY, '0, '0, '0));
		send_op(MODE_RESERVED, make_rec('0, '0, '0, '0));
		wait_for_results();
	endtask

	task automatic test_dequeue_order();
		send_op(MODE_DEQ, make_rec('0, '0, '0, '0));
		send_op(MODE_DEQ, make_rec('1, '1, '1, '1));
		wait_for_results();
	endtask

	task automatic run_random_phase(input int n_items, input int idle_pct,
			input int stall_pct);
		logic [MODE_W-1:0] op;
		rec_t item;
		int roll;
		bit filling;
		filling = 1'b1;
		sender_idle_pct = idle_pct;
		recv_stall_pct = stall_pct;
		foreach (key_pool[j])
			key_pool[j] = KEY_W'($urandom_range(0, 65535));
		for (int i = 0; i < n_items; i++) begin
			// Swing between filling and draining so both ends of the ring get hit
			if (ring_count == DEPTH && $urandom_range(0, 3) == 0)
				filling = 1'b0;
			else if (ring_count == 0 && $urandom_range(0, 3) == 0)
				filling = 1'b1;
			else if ($urandom_range(0, 49) == 0)
				filling = !filling;
			roll = $urandom_range(0, 99);
			if (roll < 5)
				op = MODE_RESERVED;
			else if (roll < 30)
				op = MODE_LOOKUP;
			else if (roll < (filling ? 80 : 45))
				op = MODE_ENQ;
			else
				op = MODE_DEQ;
			item = make_rec(pick_key(op), DUR_W'($urandom_range(0, 1023)),
				SPL_W'($urandom_range(0, 1023)), PRC_W'($urandom_range(0, 65535)));
			send_op(op, item);
		end
		wait_for_results();
	endtask

	task automatic test_random_traffic();
		run_random_phase(275, 0, 0);
		run_random_phase(275, 48, 0);
		run_random_phase(275, 0, 48);
		run_random_phase(275, 36, 36);
	endtask

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_empty_queue();
		test_fill_and_search();
		test_dequeue_order();
		test_random_traffic();
		// Give any stray result time to surface
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatch_count == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
